/* rtl/sleep_leakage_drift_estimator_unit_defines.svh */
// Assertion macros for the leakage drift estimator.
// Define ASSERT_OFF to compile the checks out.
`ifndef SLEEP_LEAKAGE_DRIFT_ESTIMATOR_UNIT_DEFINES_SVH
`define SLEEP_LEAKAGE_DRIFT_ESTIMATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define SLDEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sldeu: same-cycle check failed");

`define SLDEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sldeu: next-cycle check failed");

`else

`define SLDEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SLDEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/sldeu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sldeu_pkg;

	localparam int ADC_BITS  = 12;
	localparam int STAMP_W   = 32;
	localparam int MODEL_W   = 24;
	localparam int MINSLP_W  = 16;
	localparam int SLOPE_W   = 32;
	localparam int ALPHA_W   = 9;
	localparam int GAIN_W    = 20;
	localparam int CNT_W     = 32;
	localparam int DRIFT_W   = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// Droop numerator: count drop times 1000 ms/s, then Q16.
	localparam int MS_PER_S   = 1000;
	localparam int MS_W       = 10;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_W      = ADC_BITS + MS_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(NUM_W);

	// Shared multiplier operand widths.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 20;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Width of one weighted smoothing term, and of their rounded sum.
	localparam int ACC_W = SLOPE_W + ALPHA_W;
	localparam int SUM_W = ACC_W + 1;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

	typedef enum logic [1:0] {
		OP_PRE    = 2'd0,
		OP_POST   = 2'd1,
		OP_UPDATE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_SHORT   = 3'd1,
		ST_ROSE    = 3'd2,
		ST_STEEP   = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODEL  = 3'd0,
		REG_DELTA  = 3'd1,
		REG_MINSLP = 3'd2,
		REG_MAXSLP = 3'd3,
		REG_ALPHA  = 3'd4,
		REG_GAIN   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		op_t                 op;
		logic [ADC_BITS-1:0] vcap_counts;
		logic [STAMP_W-1:0]  time_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        leak_estimate_pa;
		status_t            status;
		logic               estimate_updated;
		logic [CNT_W-1:0]   update_total;
		logic [CNT_W-1:0]   measurement_total;
		logic [DRIFT_W-1:0] drift_sum_pa;
		logic               significant_drift;
	} out_item_t;

	typedef struct packed {
		logic                start;
		logic [NUM_W-1:0]    dividend;
		logic [STAMP_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [NUM_W-1:0]    quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/sldeu_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module sldeu_div import sldeu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [STAMP_W-1:0]   rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [STAMP_W-1:0]   divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [STAMP_W:0]     trial;
	logic                 fits;
	logic [STAMP_W:0]     diff;

	// Restoring division: the dividend shifts out of the top of quo_q while
	// quotient bits shift in at the bottom, one bit per cycle.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/sldeu_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module sldeu_mul import sldeu_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  product_q
);

	// The product is registered every cycle; the sequencer picks the
	// operands one state ahead of the one that uses the result.
	always_ff @(posedge clk) begin
		product_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

/* rtl/sleep_leakage_drift_estimator_unit.sv */
// Sequence: a record or clear item goes straight to S_OUT, which registers out_valid; an update
// rejected on its window leaves S_CHECK for S_OUT, and one whose slope is too steep leaves S_DIV for S_OUT.
// A full update spends its time on the bit-serial divider and the shared multiplier.
// Items: the block takes no new item before it has loaded the output for the last one; a
// stalled output holds the block until the result is taken.
// Reset: arst_n clears all statistics and records and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "sleep_leakage_drift_estimator_unit_defines.svh"

module sleep_leakage_drift_estimator_unit import sldeu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_CHECK   = 11'b000_0000_0010,
		S_DIVLOAD = 11'b000_0000_0100,
		S_DIV     = 11'b000_0000_1000,
		S_MULB    = 11'b000_0001_0000,
		S_MULC    = 11'b000_0010_0000,
		S_MULD    = 11'b000_0100_0000,
		S_SCALE   = 11'b000_1000_0000,
		S_CMP     = 11'b001_0000_0000,
		S_APPLY   = 11'b010_0000_0000,
		S_OUT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [MODEL_W-1:0]  model_q;
	logic [MODEL_W-1:0]  delta_q;
	logic [MINSLP_W-1:0] min_sleep_q;
	logic [SLOPE_W-1:0]  max_slope_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [GAIN_W-1:0]   gain_q;

	// Measurement state.
	logic [ADC_BITS-1:0] start_counts_q;
	logic [STAMP_W-1:0]  start_stamp_q;
	logic [ADC_BITS-1:0] end_counts_q;
	logic [STAMP_W-1:0]  end_stamp_q;
	logic                pending_q;
	logic [SLOPE_W-1:0]  smoothed_q;
	logic [31:0]         estimate_q;
	logic [CNT_W-1:0]    updates_q;
	logic [CNT_W-1:0]    measurements_q;
	logic [DRIFT_W-1:0]  drift_q;
	status_t             status_q;
	logic                replaced_q;
	logic                out_valid_q;

	// Working registers of an update.
	logic [STAMP_W-1:0]  duration_q;
	logic [ACC_W-1:0]    acc_q;
	logic [31:0]         newpa_q;
	logic [31:0]         diff_q;
	out_item_t           out_q;

	logic                accept;
	logic                load_out;
	logic [STAMP_W-1:0]  duration;
	logic                too_short;
	logic                rose;
	logic [ALPHA_W-1:0]  alpha_eff;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   product_q;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                steep;
	logic [SUM_W-1:0]    smooth_sum;
	logic [PROD_W:0]     scale_sum;
	logic [31:0]         newpa_sat;
	logic [31:0]         model_ext;
	logic [31:0]         diff_next;
	logic [DRIFT_W:0]    drift_add;
	logic [DRIFT_W-1:0]  drift_next;
	logic [DRIFT_W+3:0]  drift_x10;
	logic                significant;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign duration  = end_stamp_q - start_stamp_q;
	assign too_short = duration < STAMP_W'(min_sleep_q);
	assign rose      = end_counts_q > start_counts_q;

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// Operands for the product that the next state reads.
	always_comb begin
		unique case (state_q)
			S_CHECK: begin
				mul_a = MUL_A_W'(start_counts_q - end_counts_q);
				mul_b = MUL_B_W'(MS_PER_S);
			end
			S_DIV: begin
				mul_a = div_rsp.quotient[SLOPE_W-1:0];
				mul_b = MUL_B_W'(alpha_eff);
			end
			S_MULB: begin
				mul_a = smoothed_q;
				mul_b = MUL_B_W'(ALPHA_ONE - alpha_eff);
			end
			S_MULD: begin
				mul_a = smoothed_q;
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sldeu_mul u_mul (
		.clk       (clk),
		.a         (mul_a),
		.b         (mul_b),
		.product_q (product_q)
	);

	assign div_req.start    = (state_q == S_DIVLOAD);
	assign div_req.dividend = {product_q[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
	assign div_req.divisor  = duration_q;

	sldeu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign steep = div_rsp.quotient > NUM_W'(max_slope_q);

	// Moving average, rounded, kept to 32 bits.
	assign smooth_sum = SUM_W'(acc_q) + SUM_W'(product_q[ACC_W-1:0]) + SUM_W'(128);

	// Scale to picoamperes with rounding, then saturate to 32 bits.
	assign scale_sum = {1'b0, product_q} + (PROD_W+1)'(32768);
	assign newpa_sat = (|scale_sum[PROD_W:FRAC_BITS+32]) ? '1 : scale_sum[FRAC_BITS+31:FRAC_BITS];

	assign model_ext = 32'(model_q);
	assign diff_next = (newpa_q >= model_ext) ? (newpa_q - model_ext) : (model_ext - newpa_q);

	assign drift_add  = (DRIFT_W+1)'(drift_q) + (DRIFT_W+1)'(diff_q);
	assign drift_next = drift_add[DRIFT_W] ? '1 : drift_add[DRIFT_W-1:0];

	assign drift_x10   = (DRIFT_W+4)'({drift_q, 3'b000}) + (DRIFT_W+4)'({drift_q, 1'b0});
	assign significant = drift_x10 > (DRIFT_W+4)'(model_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			model_q        <= '0;
			delta_q        <= MODEL_W'(5000);
			min_sleep_q    <= MINSLP_W'(10);
			max_slope_q    <= SLOPE_W'(813242);
			alpha_q        <= ALPHA_W'(77);
			gain_q         <= GAIN_W'(80586);
			start_counts_q <= '0;
			start_stamp_q  <= '0;
			end_counts_q   <= '0;
			end_stamp_q    <= '0;
			pending_q      <= 1'b0;
			smoothed_q     <= '0;
			estimate_q     <= '0;
			updates_q      <= '0;
			measurements_q <= '0;
			drift_q        <= '0;
			status_q       <= ST_DONE;
			replaced_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q   <= ST_DONE;
						replaced_q <= 1'b0;
						state_q    <= S_OUT;
						unique case (in_item.op)
							OP_PRE: begin
								start_counts_q <= in_item.vcap_counts;
								start_stamp_q  <= in_item.time_ms;
								pending_q      <= 1'b1;
							end
							OP_POST: begin
								if (pending_q) begin
									end_counts_q <= in_item.vcap_counts;
									end_stamp_q  <= in_item.time_ms;
									pending_q    <= 1'b0;
								end else begin
									status_q <= ST_IGNORED;
								end
							end
							OP_UPDATE: begin
								state_q <= S_CHECK;
							end
							OP_CLEAR: begin
								drift_q        <= '0;
								updates_q      <= '0;
								measurements_q <= '0;
								estimate_q     <= 32'(model_q);
							end
						endcase
					end
				end
				S_CHECK: begin
					// The window is tested before the direction of the droop.
					if (too_short) begin
						status_q <= ST_SHORT;
						state_q  <= S_OUT;
					end else if (rose) begin
						status_q <= ST_ROSE;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_DIVLOAD;
					end
				end
				S_DIVLOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (steep) begin
							status_q <= ST_STEEP;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_MULB;
						end
					end
				end
				S_MULB: begin
					state_q <= S_MULC;
				end
				S_MULC: begin
					smoothed_q <= smooth_sum[SLOPE_W+7:8];
					state_q    <= S_MULD;
				end
				S_MULD: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (measurements_q != '1) begin
						measurements_q <= measurements_q + 1'b1;
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (diff_q > 32'(delta_q)) begin
						estimate_q <= newpa_q;
						drift_q    <= drift_next;
						if (updates_q != '1) begin
							updates_q <= updates_q + 1'b1;
						end
						replaced_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// The user must write only while the block is idle; the block itself does not enforce it.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODEL: begin
						model_q    <= cfg_data[MODEL_W-1:0];
						estimate_q <= 32'(cfg_data[MODEL_W-1:0]);
					end
					REG_DELTA:  delta_q     <= cfg_data[MODEL_W-1:0];
					REG_MINSLP: min_sleep_q <= cfg_data[MINSLP_W-1:0];
					REG_MAXSLP: max_slope_q <= cfg_data[SLOPE_W-1:0];
					REG_ALPHA:  alpha_q     <= cfg_data[ALPHA_W-1:0];
					REG_GAIN:   gain_q      <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			// A zero window can only pass the length test with no minimum set.
			duration_q <= (duration == '0) ? STAMP_W'(1) : duration;
		end
		if (state_q == S_MULB) begin
			acc_q <= product_q[ACC_W-1:0];
		end
		if (state_q == S_SCALE) begin
			newpa_q <= newpa_sat;
		end
		if (state_q == S_CMP) begin
			diff_q <= diff_next;
		end
		if (load_out) begin
			out_q.leak_estimate_pa  <= estimate_q;
			out_q.status            <= status_q;
			out_q.estimate_updated  <= replaced_q;
			out_q.update_total      <= updates_q;
			out_q.measurement_total <= measurements_q;
			out_q.drift_sum_pa      <= drift_q;
			out_q.significant_drift <= significant;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`SLDEU_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV)
	`SLDEU_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)
	`SLDEU_ASSERT_IMP(a_updates_bounded, clk, arst_n, 1'b1, updates_q <= measurements_q)
	`SLDEU_ASSERT_IMP(a_replace_only_done, clk, arst_n, out_valid_q && out_q.estimate_updated, out_q.status == ST_DONE)

endmodule

`default_nettype wire
